// ----- sv/irg_pkg.sv -----
`default_nettype none
package irg_pkg;

   localparam int unsigned TABLE_DEPTH = 256;
   localparam int unsigned ADDR_W      = 8;
   localparam int unsigned WORD_W      = 32;
   localparam int unsigned LEFT_W      = 9;

   typedef logic [WORD_W-1:0] word_type;
   typedef logic [ADDR_W-1:0] addr_type;
   typedef logic [LEFT_W-1:0] left_type;
   typedef word_type [7:0]    mix_vec_type;

   localparam word_type GOLDEN     = 32'h9e3779b9;
   localparam addr_type HALF_TABLE = 8'd128;
   localparam left_type FULL_BATCH = 9'd256;

   localparam logic [1:0] KIND_SEED        = 2'd0;
   localparam logic [1:0] KIND_INIT_SEEDED = 2'd1;
   localparam logic [1:0] KIND_INIT_PLAIN  = 2'd2;
   localparam logic [1:0] KIND_DRAW        = 2'd3;

   typedef struct packed {
      logic [1:0] kind;
      addr_type   seed_index;
      word_type   seed_value;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } queue_out_type;

   function automatic mix_vec_type scramble_step(input mix_vec_type w, input logic [2:0] k);
      mix_vec_type r;
      word_type    sh;
      logic [2:0]  k1;
      logic [2:0]  k2;
      logic [2:0]  k3;
      k1 = k + 3'd1;
      k2 = k + 3'd2;
      k3 = k + 3'd3;
      case (k)
         3'd0: sh = w[k1] << 11;
         3'd1: sh = w[k1] >> 2;
         3'd2: sh = w[k1] << 8;
         3'd3: sh = w[k1] >> 16;
         3'd4: sh = w[k1] << 10;
         3'd5: sh = w[k1] >> 4;
         3'd6: sh = w[k1] << 8;
         default: sh = w[k1] >> 9;
      endcase
      r     = w;
      r[k]  = w[k] ^ sh;
      r[k3] = w[k3] + r[k];
      r[k1] = w[k1] + w[k2];
      return r;
   endfunction

   function automatic word_type acc_shift(input word_type a, input logic [1:0] sel);
      word_type r;
      case (sel)
         2'd0: r = a ^ (a << 13);
         2'd1: r = a ^ (a >> 6);
         2'd2: r = a ^ (a << 2);
         default: r = a ^ (a >> 16);
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

// ----- sv/irg_req_if.sv -----
`default_nettype none
interface irg_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [7:0]  seed_index;
   logic [31:0] seed_value;
   modport source (output valid, output kind, output seed_index, output seed_value,
                   input ready);
   modport sink (input valid, input kind, input seed_index, input seed_value,
                 output ready);
endinterface
`default_nettype wire

// ----- sv/irg_rsp_if.sv -----
`default_nettype none
interface irg_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] random_value;
   modport source (output valid, output random_value, input ready);
   modport sink (input valid, input random_value, output ready);
endinterface
`default_nettype wire

// ----- sv/irg_front.sv -----
`default_nettype none
module irg_front
   import irg_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   irg_req_if.sink      req_chan,
   output queue_out_type q_out,
   input  wire logic    q_take
);

   item_type   entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   logic       pop;
   item_type   incoming;

   always_comb begin
      incoming.kind       = req_chan.kind;
      incoming.seed_index = req_chan.seed_index;
      incoming.seed_value = req_chan.seed_value;
      req_chan.ready      = (count_ff != 2'd2);
      push                = req_chan.valid && req_chan.ready;
      q_out.valid         = (count_ff != 2'd0);
      q_out.item          = entry_ff[rd_ptr_ff];
      pop                 = q_take && q_out.valid;
      wr_ptr_in           = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in           = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in            = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= incoming;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule
`default_nettype wire

// ----- sv/irg_back.sv -----
`default_nettype none
module irg_back
   import irg_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire queue_out_type q_out,
   output logic               q_take,
   irg_rsp_if.source          rsp_chan
);

   localparam logic [3:0] ST_CLEAR      = 4'd0;
   localparam logic [3:0] ST_IDLE       = 4'd1;
   localparam logic [3:0] ST_DRAW_ISSUE = 4'd2;
   localparam logic [3:0] ST_DRAW_RD    = 4'd3;
   localparam logic [3:0] ST_INIT_SCR   = 4'd4;
   localparam logic [3:0] ST_BLK_LOAD   = 4'd5;
   localparam logic [3:0] ST_BLK_ADD    = 4'd6;
   localparam logic [3:0] ST_BLK_SCR    = 4'd7;
   localparam logic [3:0] ST_BLK_STORE  = 4'd8;
   localparam logic [3:0] ST_RG_START   = 4'd9;
   localparam logic [3:0] ST_RG1        = 4'd10;
   localparam logic [3:0] ST_RG2        = 4'd11;
   localparam logic [3:0] ST_RG3        = 4'd12;
   localparam logic [3:0] ST_RG4        = 4'd13;
   localparam logic [3:0] ST_RG5        = 4'd14;

   word_type res_mem [TABLE_DEPTH];
   word_type mix_mem [TABLE_DEPTH];

   logic [3:0]  state_ff, state_in;
   addr_type    cnt_ff, cnt_in;
   logic [2:0]  step_ff, step_in;
   logic [1:0]  round_ff, round_in;
   logic        pass_ff, pass_in;
   logic        seeded_ff, seeded_in;
   logic        draw_ff, draw_in;
   mix_vec_type w_ff, w_in;
   word_type    acc_a_ff, acc_a_in;
   word_type    acc_b_ff, acc_b_in;
   word_type    batch_ff, batch_in;
   left_type    left_ff, left_in;
   word_type    x_ff, x_in;
   word_type    y_ff, y_in;
   logic        out_valid_ff, out_valid_in;
   word_type    out_data_ff, out_data_in;

   logic     res_we;
   addr_type res_waddr, res_raddr;
   word_type res_wdata, res_rdata_ff;
   logic     mix_we;
   addr_type mix_waddr, mix_raddr;
   word_type mix_wdata, mix_rdata_ff;
   word_type y_sum;
   word_type b_sum;
   word_type load_word;
   left_type left_dec;

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.random_value = out_data_ff;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      step_in      = step_ff;
      round_in     = round_ff;
      pass_in      = pass_ff;
      seeded_in    = seeded_ff;
      draw_in      = draw_ff;
      w_in         = w_ff;
      acc_a_in     = acc_a_ff;
      acc_b_in     = acc_b_ff;
      batch_in     = batch_ff;
      left_in      = left_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      out_valid_in = out_valid_ff && !rsp_chan.ready;
      out_data_in  = out_data_ff;
      q_take       = 1'b0;
      res_we       = 1'b0;
      res_waddr    = cnt_ff;
      res_wdata    = '0;
      res_raddr    = {cnt_ff[4:0], step_ff};
      mix_we       = 1'b0;
      mix_waddr    = cnt_ff;
      mix_wdata    = '0;
      mix_raddr    = {cnt_ff[4:0], step_ff};
      y_sum        = mix_rdata_ff + acc_a_ff + acc_b_ff;
      b_sum        = mix_rdata_ff + x_ff;
      load_word    = pass_ff ? mix_rdata_ff : res_rdata_ff;
      left_dec     = left_ff - 9'd1;

      case (state_ff)
         ST_CLEAR: begin
            res_we = 1'b1;
            mix_we = 1'b1;
            cnt_in = cnt_ff + 8'd1;
            if (cnt_ff == 8'd255) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (q_out.valid) begin
               case (q_out.item.kind)
                  KIND_SEED: begin
                     q_take    = 1'b1;
                     res_we    = 1'b1;
                     res_waddr = q_out.item.seed_index;
                     res_wdata = q_out.item.seed_value;
                  end
                  KIND_INIT_SEEDED, KIND_INIT_PLAIN: begin
                     q_take    = 1'b1;
                     seeded_in = (q_out.item.kind == KIND_INIT_SEEDED);
                     acc_a_in  = '0;
                     acc_b_in  = '0;
                     batch_in  = '0;
                     w_in      = {8{GOLDEN}};
                     step_in   = 3'd0;
                     round_in  = 2'd0;
                     state_in  = ST_INIT_SCR;
                  end
                  default: begin
                     if (!out_valid_ff) begin
                        q_take = 1'b1;
                        if (left_ff == 9'd0) begin
                           draw_in  = 1'b1;
                           state_in = ST_RG_START;
                        end else begin
                           state_in = ST_DRAW_ISSUE;
                        end
                     end
                  end
               endcase
            end
         end
         ST_DRAW_ISSUE: begin
            res_raddr = left_dec[ADDR_W-1:0];
            left_in   = left_dec;
            state_in  = ST_DRAW_RD;
         end
         ST_DRAW_RD: begin
            out_valid_in = 1'b1;
            out_data_in  = res_rdata_ff;
            state_in     = ST_IDLE;
         end
         ST_INIT_SCR: begin
            w_in    = scramble_step(w_ff, step_ff);
            step_in = step_ff + 3'd1;
            if (step_ff == 3'd7) begin
               round_in = round_ff + 2'd1;
               if (round_ff == 2'd3) begin
                  cnt_in   = '0;
                  pass_in  = 1'b0;
                  state_in = seeded_ff ? ST_BLK_LOAD : ST_BLK_SCR;
               end
            end
         end
         ST_BLK_LOAD: begin
            state_in = ST_BLK_ADD;
         end
         ST_BLK_ADD: begin
            w_in[step_ff] = w_ff[step_ff] + load_word;
            step_in       = step_ff + 3'd1;
            state_in      = (step_ff == 3'd7) ? ST_BLK_SCR : ST_BLK_LOAD;
         end
         ST_BLK_SCR: begin
            w_in    = scramble_step(w_ff, step_ff);
            step_in = step_ff + 3'd1;
            if (step_ff == 3'd7) begin
               state_in = ST_BLK_STORE;
            end
         end
         ST_BLK_STORE: begin
            mix_we    = 1'b1;
            mix_waddr = {cnt_ff[4:0], step_ff};
            mix_wdata = w_ff[step_ff];
            step_in   = step_ff + 3'd1;
            if (step_ff == 3'd7) begin
               if (cnt_ff[4:0] == 5'd31) begin
                  cnt_in = '0;
                  if (!pass_ff && seeded_ff) begin
                     pass_in  = 1'b1;
                     state_in = ST_BLK_LOAD;
                  end else begin
                     draw_in  = 1'b0;
                     state_in = ST_RG_START;
                  end
               end else begin
                  cnt_in   = cnt_ff + 8'd1;
                  state_in = seeded_ff ? ST_BLK_LOAD : ST_BLK_SCR;
               end
            end
         end
         ST_RG_START: begin
            batch_in  = batch_ff + 32'd1;
            acc_b_in  = acc_b_ff + batch_ff + 32'd1;
            cnt_in    = '0;
            mix_raddr = '0;
            state_in  = ST_RG1;
         end
         ST_RG1: begin
            x_in      = mix_rdata_ff;
            mix_raddr = cnt_ff + HALF_TABLE;
            state_in  = ST_RG2;
         end
         ST_RG2: begin
            acc_a_in  = acc_shift(acc_a_ff, cnt_ff[1:0]) + mix_rdata_ff;
            mix_raddr = x_ff[9:2];
            state_in  = ST_RG3;
         end
         ST_RG3: begin
            mix_we    = 1'b1;
            mix_waddr = cnt_ff;
            mix_wdata = y_sum;
            y_in      = y_sum;
            state_in  = ST_RG4;
         end
         ST_RG4: begin
            mix_raddr = y_ff[17:10];
            state_in  = ST_RG5;
         end
         ST_RG5: begin
            acc_b_in  = b_sum;
            res_we    = 1'b1;
            res_waddr = cnt_ff;
            res_wdata = b_sum;
            cnt_in    = cnt_ff + 8'd1;
            mix_raddr = cnt_ff + 8'd1;
            if (cnt_ff == 8'd255) begin
               left_in  = FULL_BATCH;
               state_in = draw_ff ? ST_DRAW_ISSUE : ST_IDLE;
            end else begin
               state_in = ST_RG1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (res_we) begin
         res_mem[res_waddr] <= res_wdata;
      end
      res_rdata_ff <= res_mem[res_raddr];
      if (mix_we) begin
         mix_mem[mix_waddr] <= mix_wdata;
      end
      mix_rdata_ff <= mix_mem[mix_raddr];
   end

   always_ff @(posedge clock) begin
      step_ff     <= step_in;
      round_ff    <= round_in;
      pass_ff     <= pass_in;
      seeded_ff   <= seeded_in;
      w_ff        <= w_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      out_data_ff <= out_data_in;
      if (reset) begin
         state_ff     <= ST_CLEAR;
         cnt_ff       <= '0;
         draw_ff      <= 1'b0;
         acc_a_ff     <= '0;
         acc_b_ff     <= '0;
         batch_ff     <= '0;
         left_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         draw_ff      <= draw_in;
         acc_a_ff     <= acc_a_in;
         acc_b_ff     <= acc_b_in;
         batch_ff     <= batch_in;
         left_ff      <= left_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule
`default_nettype wire

// ----- sv/isaac_random_generator_unit.sv -----
// ISAAC 32-bit pseudo-random generator.
// req_chan carries transactions of three kinds: a seed write (kind 0) puts
// seed_value into the result store at seed_index; an init (kind 1 seeded,
// kind 2 unseeded) rebuilds the mixing table and produces the first batch;
// a draw (kind 3) returns one word on rsp_chan, taken from index 255 down.
// Only draws produce a rsp_chan transaction.
// A two-entry queue decouples acceptance from the engine, so req_chan keeps
// taking transactions while a drawn word waits on rsp_chan, until both
// queue entries are full. The mixing table has a single read port, so batch
// regeneration steps through ST_RG1 to ST_RG5 for each word. A seed write
// is handled directly in the idle state; a draw reads the result store, and
// a draw on an exhausted batch first regenerates it. A seeded init folds
// the result store and then the mixing table into the vector on two passes.
// Reset is synchronous; afterwards a clearing pass zeroes all 256 entries of
// both stores, during which queued transactions wait.
// When rsp_chan.ready is low the drawn word holds in the output register;
// later seed writes and inits proceed, the next draw waits for that slot.
`default_nettype none
module isaac_random_generator_unit
   import irg_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   irg_req_if.sink   req_chan,
   irg_rsp_if.source rsp_chan
);

   queue_out_type q_out;
   logic          q_take;

   irg_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .q_out    (q_out),
      .q_take   (q_take)
   );

   irg_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_out    (q_out),
      .q_take   (q_take),
      .rsp_chan (rsp_chan)
   );

endmodule
`default_nettype wire
